@@ hdl/impact_event_capture_defines.svh @@
// ----------------------------------------------------------------------------
// Impact event capture assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IMPACT_EVENT_CAPTURE_DEFINES_SVH
`define IMPACT_EVENT_CAPTURE_DEFINES_SVH

// Same-cycle implication.
`define IEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iec_pkg.sv @@
// ----------------------------------------------------------------------------
// Impact event capture package
// Result kinds, register map, command format and shared structs.
// ----------------------------------------------------------------------------
package iec_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BG   = 2'd0;
  localparam logic [1:0] KIND_PRE  = 2'd1;
  localparam logic [1:0] KIND_HIT  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // Register indexes (word address bits).
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_POST  = 2'd2;
  localparam logic [1:0] REG_SKIP  = 2'd3;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register reset values.
  localparam logic [15:0] START_RST = 16'd8192;
  localparam logic [15:0] END_RST   = 16'd819;
  localparam logic [15:0] POST_RST  = 16'd32;
  localparam logic [15:0] SKIP_RST  = 16'd10;

  // One g in the sample scale.
  localparam logic [15:0] ONE_G = 16'd4096;

  // What the back end has to do for one sample.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,  // history write only
    OP_SINGLE = 2'd1,  // one result together with the history write
    OP_BURST  = 2'd2   // stored history, current sample, history write
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        length;
  } cmd_t;

  typedef struct packed {
    logic [15:0] start_thr;
    logic [15:0] end_thr;
    logic [15:0] post_min;
    logic [15:0] bg_skip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        length;
    logic               last;
  } res_t;

endpackage

@@ hdl/iec_front.sv @@
// ----------------------------------------------------------------------------
// Impact event capture front end
// Takes a sample, forms its magnitude with a shared multiplier and a
// bit-pair square root, classifies it and issues one command.
// ----------------------------------------------------------------------------
module iec_front (
  input  logic               clk,
  input  logic               rst_n,
  input  iec_pkg::cfg_t      cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  input  logic               q_full,
  output logic               q_push,
  output iec_pkg::cmd_t      q_cmd
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_ROOT = 5'b00100,
    F_DYN  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic signed [15:0] sx_r, sy_r, sz_r;
  logic [31:0]        prod_r, sum_r, rad_r;
  logic [1:0]         mcnt_r;
  logic [17:0]        rem_r;
  logic [15:0]        root_r, dyn_r;
  logic [3:0]         rcnt_r;

  logic               hit_r;
  logic [15:0]        post_left_r, bg_cnt_r, len_r;

  logic signed [15:0] mul_op;
  logic signed [31:0] sq;
  logic [17:0]        rem_sh, trial;
  logic               take_bit;

  // Classification results.
  logic               start_hit, end_hit, bg_emit;
  logic [15:0]        len_inc, bg_inc;

  assign in_full = (state_r != F_IDLE);

  always_comb begin
    case (mcnt_r)
      2'd0:    mul_op = sx_r;
      2'd1:    mul_op = sy_r;
      default: mul_op = sz_r;
    endcase
  end
  assign sq = mul_op * mul_op;

  assign rem_sh   = {rem_r[15:0], rad_r[31:30]};
  assign trial    = {root_r, 2'b01};
  assign take_bit = (rem_sh >= trial);

  assign start_hit = !hit_r && (dyn_r > cfg.start_thr);
  assign len_inc   = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
  assign end_hit   = hit_r && (dyn_r < cfg.end_thr) && (post_left_r == 16'd0);
  assign bg_inc    = (bg_cnt_r == 16'hFFFF) ? bg_cnt_r : bg_cnt_r + 16'd1;
  assign bg_emit   = (bg_inc >= cfg.bg_skip);

  always_comb begin
    q_cmd.x      = sx_r;
    q_cmd.y      = sy_r;
    q_cmd.z      = sz_r;
    q_cmd.length = 16'd0;
    if (start_hit) begin
      q_cmd.op   = iec_pkg::OP_BURST;
      q_cmd.kind = iec_pkg::KIND_HIT;
    end else if (end_hit) begin
      q_cmd.op     = iec_pkg::OP_SINGLE;
      q_cmd.kind   = iec_pkg::KIND_END;
      q_cmd.length = len_inc;
    end else if (hit_r) begin
      q_cmd.op   = iec_pkg::OP_SINGLE;
      q_cmd.kind = iec_pkg::KIND_HIT;
    end else begin
      q_cmd.op   = bg_emit ? iec_pkg::OP_SINGLE : iec_pkg::OP_NONE;
      q_cmd.kind = iec_pkg::KIND_BG;
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_push) state_nxt = F_MUL;
      F_MUL:   if (mcnt_r == 2'd3) state_nxt = F_ROOT;
      F_ROOT:  if (rcnt_r == 4'd15) state_nxt = F_DYN;
      F_DYN:   state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      hit_r       <= 1'b0;
      post_left_r <= 16'd0;
      bg_cnt_r    <= 16'd0;
      len_r       <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (q_push) begin
        if (start_hit) begin
          hit_r       <= 1'b1;
          post_left_r <= cfg.post_min;
          len_r       <= 16'd1;
        end else if (hit_r) begin
          len_r <= len_inc;
          if (end_hit) begin
            hit_r <= 1'b0;
          end else if (post_left_r != 16'd0) begin
            post_left_r <= post_left_r - 16'd1;
          end
        end else begin
          bg_cnt_r <= bg_emit ? 16'd0 : bg_inc;
        end
      end
    end
  end

  // Datapath, no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        sx_r   <= in_x;
        sy_r   <= in_y;
        sz_r   <= in_z;
        mcnt_r <= 2'd0;
        sum_r  <= 32'd0;
      end
      F_MUL: begin
        prod_r <= unsigned'(sq);
        mcnt_r <= mcnt_r + 2'd1;
        if (mcnt_r != 2'd0) sum_r <= sum_r + prod_r;
        if (mcnt_r == 2'd3) begin
          rad_r  <= sum_r + prod_r;
          rem_r  <= 18'd0;
          root_r <= 16'd0;
          rcnt_r <= 4'd0;
        end
      end
      F_ROOT: begin
        rad_r  <= {rad_r[29:0], 2'b00};
        rcnt_r <= rcnt_r + 4'd1;
        if (take_bit) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[14:0], 1'b0};
        end
      end
      F_DYN: begin
        dyn_r <= (root_r >= iec_pkg::ONE_G) ? root_r - iec_pkg::ONE_G
                                            : iec_pkg::ONE_G - root_r;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/iec_queue.sv @@
// ----------------------------------------------------------------------------
// Impact event capture command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module iec_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  iec_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output iec_pkg::cmd_t rd_data,
  output logic          empty
);

  iec_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en && !full) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en && !empty) rd_ptr_r <= ~rd_ptr_r;
      case ({wr_en && !full, rd_en && !empty})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ hdl/iec_back.sv @@
// ----------------------------------------------------------------------------
// Impact event capture back end
// Carries out commands: replays the history memory, emits results through
// an output register and writes each sample into the history.
// ----------------------------------------------------------------------------
module iec_back #(
  parameter int unsigned PRE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  iec_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          res_valid,
  output iec_pkg::res_t res,
  input  logic          res_pop
);

  localparam int unsigned AW = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PRE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(PRE_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(PRE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(PRE_DEPTH);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_HIST = 4'b0100,
    B_CUR  = 4'b1000
  } bstate_t;

  bstate_t         state_r, state_nxt;
  iec_pkg::cmd_t   cmd_r;
  logic [AW-1:0]   ptr_r;
  logic [CW-1:0]   idx_r;
  logic [PRE_DEPTH-1:0] vld_r;
  logic [47:0]     mem_r [PRE_DEPTH];
  logic [47:0]     rd_data_r;
  logic            rd_vld_r;
  logic            out_valid_r;
  iec_pkg::res_t   out_r;

  logic            slot_free;
  logic [AW:0]     addr_sum;
  logic [AW-1:0]   rd_addr;
  logic            hist_wr;
  logic            load_pre, load_cur;
  logic [47:0]     pre_data;

  assign slot_free = !out_valid_r || res_pop;
  assign addr_sum  = {1'b0, ptr_r} + {1'b0, idx_r[AW-1:0]};
  assign rd_addr   = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : addr_sum[AW-1:0];

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign load_pre = (state_r == B_HIST) && slot_free;
  assign load_cur = (state_r == B_CUR) && (cmd_r.op != iec_pkg::OP_NONE) && slot_free;
  assign hist_wr  = (state_r == B_CUR) && ((cmd_r.op == iec_pkg::OP_NONE) || slot_free);
  assign pre_data = rd_vld_r ? rd_data_r : 48'd0;

  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = (q_cmd.op == iec_pkg::OP_BURST) ? B_READ : B_CUR;
      B_READ:  state_nxt = B_HIST;
      B_HIST:  if (slot_free) state_nxt = (idx_r == DEPTH_C) ? B_CUR : B_READ;
      B_CUR:   if (hist_wr) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ptr_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (hist_wr) begin
        vld_r[ptr_r] <= 1'b1;
        ptr_r        <= (ptr_r == LAST_PTR) ? '0 : ptr_r + AW'(1);
      end
      if (load_pre || load_cur) begin
        out_valid_r <= 1'b1;
      end else if (res_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
      idx_r <= '0;
    end
    if (state_r == B_READ) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
      idx_r     <= idx_r + CW'(1);
    end
    if (hist_wr) mem_r[ptr_r] <= {cmd_r.x, cmd_r.y, cmd_r.z};
    if (load_pre) begin
      out_r.kind   <= iec_pkg::KIND_PRE;
      out_r.x      <= pre_data[47:32];
      out_r.y      <= pre_data[31:16];
      out_r.z      <= pre_data[15:0];
      out_r.length <= 16'd0;
      out_r.last   <= 1'b0;
    end else if (load_cur) begin
      out_r.kind   <= cmd_r.kind;
      out_r.x      <= cmd_r.x;
      out_r.y      <= cmd_r.y;
      out_r.z      <= cmd_r.z;
      out_r.length <= cmd_r.length;
      out_r.last   <= 1'b1;
    end
  end

endmodule

@@ hdl/impact_event_capture.sv @@
// ----------------------------------------------------------------------------
// Impact event capture
// Pre-trigger and post-trigger capture of impact events in a stream of
// three-axis acceleration samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter through a queue-style port: a transfer happens when push is
// high and full is low. Results leave the same way: the oldest result sits
// on the out_ ports while empty is low and is transferred when pop is high.
// Registers are to be written by the user over the APB-style port only
// while the block is idle; the block itself does not enforce this. For each
// sample the front end forms the sum of squares on the shared 16x16
// multiplier, takes sixteen square-root steps, forms the dynamic
// acceleration and issues a command; it takes no new sample until it is
// back in idle. A hit start replays the history memory entry by entry (one
// read, one load of the output register each); the front end keeps working
// on later samples meanwhile, up to the two-entry command queue. Reset
// clears the hit state, counters, the history valid bits and all queues,
// and loads the register defaults. When the receiver stalls, the output
// register holds its result, the back end waits, the queue fills and full
// then stays high until results are taken again.
// ----------------------------------------------------------------------------
module impact_event_capture #(
  parameter int unsigned PRE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Sample channel
  input  logic                               push,
  output logic                               full,
  input  logic signed [15:0]                 in_accel_x,
  input  logic signed [15:0]                 in_accel_y,
  input  logic signed [15:0]                 in_accel_z,
  // Result channel
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         out_kind,
  output logic signed [15:0]                 out_x,
  output logic signed [15:0]                 out_y,
  output logic signed [15:0]                 out_z,
  output logic [15:0]                        out_event_length,
  output logic                               out_last,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [iec_pkg::ADDR_W-1:0]         paddr,
  input  logic [iec_pkg::DATA_W-1:0]         pwdata,
  output logic [iec_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  iec_pkg::cfg_t cfg_r;
  iec_pkg::cmd_t f_cmd, q_cmd;
  iec_pkg::res_t res;
  logic          f_push, q_full, q_empty, q_pop, res_valid;
  logic          cfg_wr;
  logic [15:0]   rd_word;

  // The register port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr <= iec_pkg::START_RST;
      cfg_r.end_thr   <= iec_pkg::END_RST;
      cfg_r.post_min  <= iec_pkg::POST_RST;
      cfg_r.bg_skip   <= iec_pkg::SKIP_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        iec_pkg::REG_START: cfg_r.start_thr <= pwdata[15:0];
        iec_pkg::REG_END:   cfg_r.end_thr   <= pwdata[15:0];
        iec_pkg::REG_POST:  cfg_r.post_min  <= pwdata[15:0];
        iec_pkg::REG_SKIP:  cfg_r.bg_skip   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      iec_pkg::REG_START: rd_word = cfg_r.start_thr;
      iec_pkg::REG_END:   rd_word = cfg_r.end_thr;
      iec_pkg::REG_POST:  rd_word = cfg_r.post_min;
      iec_pkg::REG_SKIP:  rd_word = cfg_r.bg_skip;
      default:            rd_word = 16'd0;
    endcase
  end
  assign prdata = {16'd0, rd_word};

  // Front end: magnitude, classification and hit bookkeeping.
  iec_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (push),
    .in_full (full),
    .in_x    (in_accel_x),
    .in_y    (in_accel_y),
    .in_z    (in_accel_z),
    .q_full  (q_full),
    .q_push  (f_push),
    .q_cmd   (f_cmd)
  );

  // Commands wait here while the back end replays history or is stalled.
  iec_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data (f_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  // Back end: history memory and the output register.
  iec_back #(
    .PRE_DEPTH (PRE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop && res_valid)
  );

  assign empty            = !res_valid;
  assign out_kind         = res.kind;
  assign out_x            = res.x;
  assign out_y            = res.y;
  assign out_z            = res.z;
  assign out_event_length = res.length;
  assign out_last         = res.last;

endmodule

@@ hdl/iec_checker.sv @@
// ----------------------------------------------------------------------------
// Impact event capture checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "impact_event_capture_defines.svh"

module iec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         out_kind,
  input logic signed [15:0] out_x,
  input logic [15:0]        out_event_length,
  input logic               out_last
);

  // A waiting result that is not taken stays put.
  `IEC_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(out_x) && $stable(out_kind), "result changed while stalled")

  // Only an end sample carries an event length.
  `IEC_ASSERT_IMP(a_len_zero, !empty && out_kind != iec_pkg::KIND_END, out_event_length == 16'd0, "length on a non-end result")

  // An end sample closes its burst and covers at least start and end samples.
  `IEC_ASSERT_IMP(a_end_last, !empty && out_kind == iec_pkg::KIND_END, out_last && out_event_length != 16'd0 && out_event_length != 16'd1, "bad end result")

  // History replay is always followed by the triggering sample.
  `IEC_ASSERT_IMP(a_pre_not_last, !empty && out_kind == iec_pkg::KIND_PRE, !out_last, "history result marked last")

endmodule

bind impact_event_capture iec_checker u_iec_checker (.*);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Impact event capture testbench
// Feeds three-axis samples through the sample queue port and follows each
// transfer with a cycle-free prediction of the capture behavior. That covers
// hit start with history replay, hit samples, the end sample with its length,
// and decimated background. Every result transfer is checked field by field.
// The registers are rewritten between phases, the extremes among them, and
// each write is read back.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH   = 16;
  // Two samples can wait in the command queue behind the one in flight, so
  // this settle time covers trailing samples that produce nothing.
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS   = 28;
  localparam int RANDOM_PHASES = 8;
  // Run limit of twenty milliseconds for the watchdog.
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } accel_sample_t;

  // Clock, reset and the DUT ports. Every input starts at a known value.
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [15:0]         in_accel_x = '0;
  logic signed [15:0]         in_accel_y = '0;
  logic signed [15:0]         in_accel_z = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [1:0]                 out_kind;
  logic signed [15:0]         out_x;
  logic signed [15:0]         out_y;
  logic signed [15:0]         out_z;
  logic [15:0]                out_event_length;
  logic                       out_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [iec_pkg::ADDR_W-1:0] paddr = '0;
  logic [iec_pkg::DATA_W-1:0] pwdata = '0;
  logic [iec_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // Samples waiting to be offered, and the results the capture logic must
  // produce, oldest first.
  accel_sample_t sample_queue[$];
  iec_pkg::res_t predicted_emits[$];

  // Our own copy of the register file, kept in step with every write.
  logic [15:0] start_thr = iec_pkg::START_RST;
  logic [15:0] end_thr   = iec_pkg::END_RST;
  logic [15:0] post_cfg  = iec_pkg::POST_RST;
  logic [15:0] skip_cfg  = iec_pkg::SKIP_RST;

  // Capture state as the predictor sees it, all cleared by reset.
  logic          hit_on = 1'b0;
  logic [15:0]   post_remaining = '0;
  logic [15:0]   bg_count = '0;
  logic [15:0]   event_len = '0;
  accel_sample_t history_mem [HIST_DEPTH];
  int            hist_head = 0;

  // One result is held back while a sample is being predicted, so that the
  // final one of the sample can get its last flag before it is queued.
  iec_pkg::res_t staged;
  bit            staged_valid = 1'b0;

  int  mismatch_count = 0;
  int  reg_errors = 0;
  int  items_taken = 0;
  bit  steady = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  holds_done = 0;

  impact_event_capture #(
    .PRE_DEPTH(HIST_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_event_length(out_event_length),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) history_mem[i] = '0;
  end

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Appends a sample to the stimulus queue.
  function automatic void add_sample(input accel_sample_t s);
    sample_queue.insert(sample_queue.size(), s);
  endfunction

  // Appends a result to the expected stream.
  function automatic void add_emit(input iec_pkg::res_t r);
    predicted_emits.insert(predicted_emits.size(), r);
  endfunction

  // Floor square root, one result bit per step from the top. The sum of
  // squares of three 16-bit values stays below 2^32, so 17 bits suffice.
  function automatic int unsigned floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  task automatic stage_result(input logic [1:0] kind, input accel_sample_t s,
                              input logic [15:0] len);
    if (staged_valid) add_emit(staged);
    staged.kind   = kind;
    staged.x      = s.x;
    staged.y      = s.y;
    staged.z      = s.z;
    staged.length = len;
    staged.last   = 1'b0;
    staged_valid  = 1'b1;
  endtask

  // Works out what one transferred sample makes the block emit, and moves
  // the capture state on by that sample.
  task automatic predict_emits(input accel_sample_t s);
    longint      sx;
    longint      sy;
    longint      sz;
    logic [63:0] energy;
    int unsigned mag;
    int unsigned dyn;
    sx = $signed(s.x);
    sy = $signed(s.y);
    sz = $signed(s.z);
    energy = sx * sx + sy * sy + sz * sz;
    mag = floor_sqrt(energy);
    // Dynamic acceleration is the distance of the magnitude from 1 g.
    dyn = (mag >= iec_pkg::ONE_G) ? mag - iec_pkg::ONE_G : iec_pkg::ONE_G - mag;

    if (!hit_on && dyn > start_thr) begin
      // Hit start: the stored history goes out oldest first, then the
      // current sample. Entries never written read as zero.
      hit_on = 1'b1;
      post_remaining = post_cfg;
      event_len = 16'd1;
      for (int i = 0; i < HIST_DEPTH; i++)
        stage_result(iec_pkg::KIND_PRE, history_mem[(hist_head + i) % HIST_DEPTH], 16'd0);
      stage_result(iec_pkg::KIND_HIT, s, 16'd0);
    end else if (hit_on) begin
      if (event_len != 16'hFFFF) event_len++;
      // The end needs a quiet sample and the minimum post count used up.
      if (dyn < end_thr && post_remaining == 16'd0) begin
        hit_on = 1'b0;
        stage_result(iec_pkg::KIND_END, s, event_len);
      end else begin
        if (post_remaining != 16'd0) post_remaining--;
        stage_result(iec_pkg::KIND_HIT, s, 16'd0);
      end
    end else begin
      // Idle decimation. A skip of zero behaves like one, since the count
      // is always at least one here.
      if (bg_count != 16'hFFFF) bg_count++;
      if (bg_count >= skip_cfg) begin
        bg_count = '0;
        stage_result(iec_pkg::KIND_BG, s, 16'd0);
      end
    end

    history_mem[hist_head] = s;
    hist_head = (hist_head + 1) % HIST_DEPTH;

    if (staged_valid) begin
      staged.last = 1'b1;
      add_emit(staged);
      staged_valid = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sample driver
  // --------------------------------------------------------------------------
  // A sample stays on the port until it is transferred. Between samples the
  // driver may insert a gap with push low, except in the steady phase.
  always @(posedge clk) begin : sample_driver
    accel_sample_t next_sample;
    if (!rst_n) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        predict_emits({in_accel_x, in_accel_y, in_accel_z});
        items_taken <= items_taken + 1;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (!steady && sample_queue.size() != 0 && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 6) - 1;
          push <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          next_sample = sample_queue.pop_front();
          push       <= 1'b1;
          in_accel_x <= next_sample.x;
          in_accel_y <= next_sample.y;
          in_accel_z <= next_sample.z;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Pops with random stalls. Twice during the run the receiver holds off for
  // a long stretch while the driver keeps offering samples, so the internal
  // queues fill and full has to rise.
  always @(posedge clk) begin : result_monitor
    iec_pkg::res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_emits.size() == 0) begin
          $display("%0t: result with none expected, kind %0d x %0d y %0d z %0d",
                   $time, out_kind, out_x, out_y, out_z);
          mismatch_count++;
        end else begin
          want = predicted_emits.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("x", $signed(want.x), out_x);
          check_field("y", $signed(want.y), out_y);
          check_field("z", $signed(want.z), out_z);
          check_field("event_length", want.length, out_event_length);
          check_field("last", want.last, out_last);
        end
      end
      if ((holds_done == 0 && items_taken >= 60) || (holds_done == 1 && items_taken >= 200)) begin
        hold_left = 500;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register access and stimulus
  // --------------------------------------------------------------------------

  // Writes one register over the APB port, mirrors it, and reads it back.
  task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
    logic [15:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= iec_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      iec_pkg::REG_START: start_thr = value;
      iec_pkg::REG_END:   end_thr   = value;
      iec_pkg::REG_POST:  post_cfg  = value;
      iec_pkg::REG_SKIP:  skip_cfg  = value;
      default: ;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t: register %0d readback, expected %0d actual %0d",
               $time, idx, value, readback);
      reg_errors++;
    end
  endtask

  task automatic set_all(input logic [15:0] s_thr, input logic [15:0] e_thr,
                         input logic [15:0] post, input logic [15:0] skip);
    set_register(iec_pkg::REG_START, s_thr);
    set_register(iec_pkg::REG_END, e_thr);
    set_register(iec_pkg::REG_POST, post);
    set_register(iec_pkg::REG_SKIP, skip);
  endtask

  // Waits until every sample is transferred and every result is back, then
  // lets trailing samples that produce nothing work their way through.
  task automatic wait_block_idle();
    @(posedge clk);
    while (sample_queue.size() != 0 || push || predicted_emits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic accel_sample_t pack_sample(input int x, input int y, input int z);
    accel_sample_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    return s;
  endfunction

  // Puts the dominant component on a random axis.
  function automatic accel_sample_t axis_sample(input int main_v, input int a, input int b);
    case ($urandom_range(0, 2))
      0:       return pack_sample(main_v, a, b);
      1:       return pack_sample(a, main_v, b);
      default: return pack_sample(a, b, main_v);
    endcase
  endfunction

  // Resting sensor: about 1 g on one axis with a little noise.
  function automatic accel_sample_t quiet_sample();
    int main_v;
    main_v = 4096 + $urandom_range(0, 120) - 60;
    if ($urandom_range(0, 1)) main_v = -main_v;
    return axis_sample(main_v, $urandom_range(0, 160) - 80, $urandom_range(0, 160) - 80);
  endfunction

  // Single-axis sample whose dynamic acceleration is exactly d, unless the
  // axis has to be clamped at full scale.
  function automatic accel_sample_t offset_sample(input int d);
    int v;
    v = 4096 + d;
    if (v > 32767) v = 32767;
    if ($urandom_range(0, 1)) v = -v;
    return axis_sample(v, 0, 0);
  endfunction

  function automatic accel_sample_t noise_sample();
    return pack_sample($urandom, $urandom, $urandom);
  endfunction

  // Mostly well-formed impacts (a quiet lead, a few violent samples, then a
  // quiet tail long enough to close the hit), mixed with quiet runs, pure
  // noise and samples right at the thresholds.
  task automatic queue_random_phase(input int count);
    int n;
    int pick;
    int tail;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        add_sample(noise_sample());
        n++;
      end else if (pick < 4) begin
        repeat ($urandom_range(1, 6)) begin
          add_sample(quiet_sample());
          n++;
        end
      end else if (pick < 9) begin
        repeat ($urandom_range(0, 3)) begin
          add_sample(quiet_sample());
          n++;
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1))
            add_sample(noise_sample());
          else
            add_sample(offset_sample(int'(start_thr) + $urandom_range(1, 3000)));
          n++;
        end
        tail = (post_cfg > 16'd8) ? 8 : int'(post_cfg);
        repeat (tail + $urandom_range(0, 3)) begin
          add_sample(quiet_sample());
          n++;
        end
      end else begin
        if ($urandom_range(0, 1))
          add_sample(offset_sample(int'(start_thr) + $urandom_range(0, 2) - 1));
        else
          add_sample(offset_sample(int'(end_thr) + $urandom_range(0, 2) - 1));
        n++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: samples at rest and at the start threshold itself,
    // none of which starts a hit. The tenth idle sample is background.
    add_sample(pack_sample(0, 0, 0));
    add_sample(pack_sample(0, 0, 4096));
    add_sample(pack_sample(0, 0, -4096));
    add_sample(pack_sample(4096, 0, 0));
    add_sample(pack_sample(0, -4096, 0));
    add_sample(pack_sample(0, 4096, 0));
    add_sample(pack_sample(-4096, 0, 0));
    add_sample(pack_sample(0, 0, 12288));
    add_sample(pack_sample(0, 0, -12288));
    add_sample(pack_sample(100, -100, 4000));
    add_sample(pack_sample(0, 0, 4096));
    wait_block_idle();

    // Tight settings. The first hit replays a history that is not yet full,
    // so its oldest entries come out as zero. Both thresholds are hit
    // exactly and one past, and the post count runs down to zero and stays.
    set_all(16'd4096, 16'd100, 16'd2, 16'd3);
    add_sample(pack_sample(32767, 32767, 32767));
    add_sample(pack_sample(-32768, -32768, -32768));
    add_sample(pack_sample(0, 0, 4096));
    add_sample(pack_sample(0, 0, 4196));
    add_sample(pack_sample(0, 0, 4195));
    add_sample(pack_sample(0, 0, 8192));
    add_sample(pack_sample(0, 0, -8193));
    add_sample(pack_sample(0, 4096, 0));
    add_sample(pack_sample(-4096, 0, 0));
    add_sample(pack_sample(0, 0, 4096));
    add_sample(pack_sample(0, 0, 0));
    add_sample(pack_sample(0, 0, -4096));
    wait_block_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        // Everything moving starts a hit and the next sample ends it.
        1: set_all(16'd0, 16'hFFFF, 16'd0, 16'd1);
        // Nothing starts or ends, and background never comes.
        3: set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        // A zero skip emits every idle sample.
        4: set_all(16'($urandom_range(1500, 12000)), 16'($urandom_range(100, 1500)),
                   16'($urandom_range(0, 5)), 16'd0);
        default: set_all(16'($urandom_range(1500, 12000)), 16'($urandom_range(100, 1500)),
                         16'($urandom_range(0, 5)), 16'($urandom_range(1, 6)));
      endcase
      // The last phase runs with both sides always ready.
      if (p == RANDOM_PHASES - 1) steady = 1'b1;
      queue_random_phase(PHASE_ITEMS);
      wait_block_idle();
    end

    if (mismatch_count == 0 && reg_errors == 0 && predicted_emits.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb: FAIL");
    $finish;
  end

endmodule
